[hdl/mis_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and payload types for the small matrix inverse core.
// Used by mis_div and matrix_inverse_small_core; depends on nothing else.

package mis_pkg;

	localparam int ELEM_W  = 32;               // Q16.16 entry width
	localparam int FRAC_W  = 16;               // fraction bits
	localparam int TOL_W   = 31;               // tolerance register width
	localparam int LANES   = 9;                // entries of a 3x3 matrix
	localparam int PROD_W  = 2 * ELEM_W;       // product of two entries
	localparam int ADJ_W   = 2 * ELEM_W + 1;   // signed adjugate entry
	localparam int AADJ_W  = 2 * ELEM_W;       // adjugate magnitude
	localparam int HI_W    = ADJ_W - ELEM_W;   // upper slice of an adjugate entry
	localparam int DET_W   = 3 * ELEM_W + 2;   // signed exact determinant
	localparam int ABSD_W  = DET_W - 1;        // determinant magnitude
	localparam int DIV_W   = DET_W;            // divisor and remainder width

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic [1:0] dim;
		elem_t      a11;
		elem_t      a12;
		elem_t      a13;
		elem_t      a21;
		elem_t      a22;
		elem_t      a23;
		elem_t      a31;
		elem_t      a32;
		elem_t      a33;
	} mis_in_t;

	typedef struct packed {
		elem_t r11;
		elem_t r12;
		elem_t r13;
		elem_t r21;
		elem_t r22;
		elem_t r23;
		elem_t r31;
		elem_t r32;
		elem_t r33;
		elem_t determinant;
		logic  singular;
	} mis_out_t;

	// Status that rides alongside the division.
	typedef struct packed {
		logic [1:0]             dim;
		logic                   singular;
		elem_t                  det_out;
		elem_t [LANES-1:0]      orig;
		logic  [LANES-1:0]      ovf;
		logic  [LANES-1:0]      neg;
	} mis_side_t;

	// One divider stage: the remainder per lane and a word that holds the
	// dividend bits still to be consumed above the quotient bits produced.
	typedef struct packed {
		mis_side_t                          side;
		logic [DIV_W-1:0]                   dsr;
		logic [LANES-1:0][DIV_W-1:0]        rem;
		logic [LANES-1:0][ELEM_W-1:0]       lq;
	} mis_div_t;

endpackage

[hdl/mis_div.sv]
`timescale 1ns / 1ps
// Nine-lane restoring divider, one quotient bit per pipeline stage.
// Depends on mis_pkg for widths and the mis_div_t stage type.

module mis_div
	import mis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  mis_div_t in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output mis_div_t out_data
);

	function automatic mis_div_t div_step(mis_div_t d);
		mis_div_t         r;
		logic [DIV_W:0]   sh;
		logic             ge;
		r = d;
		for (int k = 0; k < LANES; k++) begin
			sh = {d.rem[k], d.lq[k][ELEM_W-1]};
			ge = (sh >= {1'b0, d.dsr});
			r.rem[k] = ge ? DIV_W'(sh - {1'b0, d.dsr}) : sh[DIV_W-1:0];
			r.lq[k]  = {d.lq[k][ELEM_W-2:0], ge};
		end
		return r;
	endfunction

	logic [ELEM_W-1:0] vld_s;
	mis_div_t          dat_s [ELEM_W];
	logic [ELEM_W:0]   adv;

	assign adv[ELEM_W] = !out_stall;

	genvar g;
	generate
		for (g = 0; g < ELEM_W; g++) begin : g_stage
			logic     vin;
			mis_div_t din;

			if (g == 0) begin : g_first
				assign vin = in_valid;
				assign din = in_data;
			end else begin : g_next
				assign vin = vld_s[g-1];
				assign din = dat_s[g-1];
			end

			// A stage may load when it is empty or its content moves on.
			assign adv[g] = !vld_s[g] || adv[g+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (adv[g]) begin
					vld_s[g] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (adv[g] && vin) begin
					dat_s[g] <= div_step(din);
				end
			end
		end
	endgenerate

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[ELEM_W-1];
	assign out_data  = dat_s[ELEM_W-1];

endmodule

[hdl/matrix_inverse_small_core.sv]
`timescale 1ns / 1ps
// Top level of the small matrix inverse core: adjugate and determinant pipeline,
// tolerance test and result formatting. Depends on mis_pkg and mis_div.
//
//   Port group   Direction  Handshake           Content
//   cfg          in         cfg_we              singular tolerance, 31 bits
//   in           in         in_valid/in_stall   mis_in_t matrix and dim
//   out          out        out_valid/out_stall mis_out_t inverse, det, flag
//
// Stages cover products, adjugate, determinant and the tolerance test, then the
// divider (one quotient bit per stage) and the output register. One transaction
// is accepted every cycle while out_stall does not hold the pipeline back.
// Reset clears all valid bits and the tolerance; payload is not reset.
// Each stage holds its content under stall and bubbles close up, so input is
// accepted while a result waits as long as some stage is empty.

module matrix_inverse_small_core
	import mis_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  mis_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output mis_out_t         out_data
);

	localparam logic [ABSD_W-1:0] RND_ONE = ABSD_W'(1) << (FRAC_W - 1);
	localparam logic [ABSD_W-1:0] RND_TWO = ABSD_W'(1) << (2 * FRAC_W - 1);
	localparam logic [ELEM_W-1:0] MAXV    = {1'b0, {(ELEM_W - 1){1'b1}}};
	localparam logic [ELEM_W-1:0] MINV    = {1'b1, {(ELEM_W - 1){1'b0}}};

	logic [TOL_W-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Valid bits and advance chain.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;
	logic div_stall, dq_valid;

	assign adv9 = !vld_s9 || !out_stall;
	assign adv8 = !vld_s8 || !div_stall;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= dq_valid;
		end
	end

	// Stage 1: embed the matrix in a 3x3 one and form the minor products.
	// Outside the leading block the diagonal is integer one and the rest
	// zero, so the determinant and the adjugate block keep their exact values.
	elem_t                    ain [LANES];
	elem_t                    mat [3][3];
	logic signed [PROD_W-1:0] prod_c [2 * LANES];

	assign ain[0] = in_data.a11;
	assign ain[1] = in_data.a12;
	assign ain[2] = in_data.a13;
	assign ain[3] = in_data.a21;
	assign ain[4] = in_data.a22;
	assign ain[5] = in_data.a23;
	assign ain[6] = in_data.a31;
	assign ain[7] = in_data.a32;
	assign ain[8] = in_data.a33;

	always_comb begin : s1_comb
		int i1, i2, j1, j2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (i < int'(in_data.dim) && j < int'(in_data.dim)) begin
					mat[i][j] = ain[3 * i + j];
				end else if (i == j) begin
					mat[i][j] = elem_t'(1);
				end else begin
					mat[i][j] = '0;
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				i1 = (i == 2) ? 0 : i + 1;
				i2 = (i == 0) ? 2 : i - 1;
				j1 = (j == 2) ? 0 : j + 1;
				j2 = (j == 0) ? 2 : j - 1;
				prod_c[2 * (3 * i + j)]     = PROD_W'(mat[j1][i1]) * PROD_W'(mat[j2][i2]);
				prod_c[2 * (3 * i + j) + 1] = PROD_W'(mat[j1][i2]) * PROD_W'(mat[j2][i1]);
			end
		end
	end

	logic signed [PROD_W-1:0] prod_s1 [2 * LANES];
	elem_t                    row_s1 [3];
	elem_t                    orig_s1 [LANES];
	logic [1:0]               dim_s1;

	// Stage 2 to stage 7 registers.
	logic signed [ADJ_W-1:0]  adj_s2 [LANES];
	elem_t                    row_s2 [3];
	elem_t                    orig_s2 [LANES];
	logic [1:0]               dim_s2;

	logic signed [ADJ_W-1:0]  pl_s3 [3];
	logic signed [ADJ_W-1:0]  ph_s3 [3];
	logic [AADJ_W-1:0]        aadj_s3 [LANES];
	logic [LANES-1:0]         sadj_s3;
	elem_t                    orig_s3 [LANES];
	logic [1:0]               dim_s3;

	logic signed [DET_W-1:0]  term_s4 [3];
	logic [AADJ_W-1:0]        aadj_s4 [LANES];
	logic [LANES-1:0]         sadj_s4;
	elem_t                    orig_s4 [LANES];
	logic [1:0]               dim_s4;

	logic signed [DET_W-1:0]  det_s5;
	logic [AADJ_W-1:0]        aadj_s5 [LANES];
	logic [LANES-1:0]         sadj_s5;
	elem_t                    orig_s5 [LANES];
	logic [1:0]               dim_s5;

	logic [ABSD_W-1:0]        absd_s6;
	logic                     dneg_s6;
	logic [AADJ_W-1:0]        aadj_s6 [LANES];
	logic [LANES-1:0]         sadj_s6;
	elem_t                    orig_s6 [LANES];
	logic [1:0]               dim_s6;

	logic                     sing_s7;
	logic [ABSD_W-1:0]        rdet_s7;
	logic                     dneg_s7;
	logic [DIV_W-1:0]         num_s7 [LANES];
	logic [DIV_W-1:0]         dsr_s7;
	logic [LANES-1:0]         neg_s7;
	elem_t                    orig_s7 [LANES];
	logic [1:0]               dim_s7;

	mis_div_t                 div_s8;

	// Stage 7 combinational: tolerance at the determinant's scale and rounding.
	logic [ABSD_W-1:0] tol_sh_c;
	logic [ABSD_W-1:0] rdet_c;

	always_comb begin
		case (dim_s6)
			2'd1: begin
				tol_sh_c = ABSD_W'(tol_q);
				rdet_c   = absd_s6;
			end
			2'd2: begin
				tol_sh_c = ABSD_W'(tol_q) << FRAC_W;
				rdet_c   = (absd_s6 + RND_ONE) >> FRAC_W;
			end
			default: begin
				tol_sh_c = ABSD_W'(tol_q) << (2 * FRAC_W);
				rdet_c   = (absd_s6 + RND_TWO) >> (2 * FRAC_W);
			end
		endcase
	end

	// Stage 8 combinational: divider setup and determinant saturation.
	mis_div_t div_c;

	always_comb begin
		div_c.dsr           = dsr_s7;
		div_c.side.dim      = dim_s7;
		div_c.side.singular = sing_s7;
		if (dneg_s7) begin
			div_c.side.det_out = (rdet_s7 > ABSD_W'(MINV)) ? elem_t'(MINV)
				: elem_t'(ELEM_W'(0) - rdet_s7[ELEM_W-1:0]);
		end else begin
			div_c.side.det_out = (rdet_s7 > ABSD_W'(MAXV)) ? elem_t'(MAXV)
				: elem_t'(rdet_s7[ELEM_W-1:0]);
		end
		for (int k = 0; k < LANES; k++) begin
			div_c.side.orig[k] = orig_s7[k];
			div_c.side.neg[k]  = neg_s7[k];
			// A quotient of 2^ELEM_W or more saturates in any case.
			div_c.side.ovf[k]  = ((num_s7[k] >> ELEM_W) >= dsr_s7);
			div_c.rem[k]       = num_s7[k] >> ELEM_W;
			div_c.lq[k]        = num_s7[k][ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			prod_s1 <= prod_c;
			row_s1  <= mat[0];
			orig_s1 <= ain;
			dim_s1  <= in_data.dim;
		end
		if (adv2 && vld_s1) begin
			for (int k = 0; k < LANES; k++) begin
				adj_s2[k] <= ADJ_W'(prod_s1[2 * k]) - ADJ_W'(prod_s1[2 * k + 1]);
			end
			row_s2  <= row_s1;
			orig_s2 <= orig_s1;
			dim_s2  <= dim_s1;
		end
		if (adv3 && vld_s2) begin
			// Each first-row product is split into two narrow partial products.
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= ADJ_W'(row_s2[j])
					* ADJ_W'($signed({1'b0, adj_s2[3 * j][ELEM_W-1:0]}));
				ph_s3[j] <= ADJ_W'(row_s2[j])
					* ADJ_W'($signed(adj_s2[3 * j][ADJ_W-1:ELEM_W]));
			end
			for (int k = 0; k < LANES; k++) begin
				aadj_s3[k] <= adj_s2[k][ADJ_W-1] ? AADJ_W'(-adj_s2[k]) : AADJ_W'(adj_s2[k]);
				sadj_s3[k] <= adj_s2[k][ADJ_W-1];
			end
			orig_s3 <= orig_s2;
			dim_s3  <= dim_s2;
		end
		if (adv4 && vld_s3) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (DET_W'(ph_s3[j]) <<< ELEM_W) + DET_W'(pl_s3[j]);
			end
			aadj_s4 <= aadj_s3;
			sadj_s4 <= sadj_s3;
			orig_s4 <= orig_s3;
			dim_s4  <= dim_s3;
		end
		if (adv5 && vld_s4) begin
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			aadj_s5 <= aadj_s4;
			sadj_s5 <= sadj_s4;
			orig_s5 <= orig_s4;
			dim_s5  <= dim_s4;
		end
		if (adv6 && vld_s5) begin
			absd_s6 <= det_s5[DET_W-1] ? ABSD_W'(-det_s5) : ABSD_W'(det_s5);
			dneg_s6 <= det_s5[DET_W-1];
			aadj_s6 <= aadj_s5;
			sadj_s6 <= sadj_s5;
			orig_s6 <= orig_s5;
			dim_s6  <= dim_s5;
		end
		if (adv7 && vld_s6) begin
			sing_s7 <= (dim_s6 == 2'd0) || (absd_s6 <= tol_sh_c);
			rdet_s7 <= rdet_c;
			dneg_s7 <= dneg_s6;
			// Rounded quotient is floor((2|adj| 2^32 + |D|) / (2|D|)).
			for (int k = 0; k < LANES; k++) begin
				num_s7[k] <= (DIV_W'(aadj_s6[k]) << (2 * FRAC_W + 1)) + DIV_W'(absd_s6);
				neg_s7[k] <= sadj_s6[k] ^ dneg_s6;
			end
			dsr_s7  <= DIV_W'(absd_s6) << 1;
			orig_s7 <= orig_s6;
			dim_s7  <= dim_s6;
		end
		if (adv8 && vld_s7) begin
			div_s8 <= div_c;
		end
	end

	mis_div_t dq;

	mis_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s8),
		.in_stall  (div_stall),
		.in_data   (div_s8),
		.out_valid (dq_valid),
		.out_stall (!adv9),
		.out_data  (dq)
	);

	// Output formatting: saturate, select pass-through and clear unused entries.
	elem_t    res_c [LANES];
	mis_out_t res_s9;

	always_comb begin : fmt_comb
		elem_t val;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (dq.side.neg[3 * i + j]) begin
					val = (dq.side.ovf[3 * i + j] || dq.lq[3 * i + j] > MINV) ? elem_t'(MINV)
						: elem_t'(ELEM_W'(0) - dq.lq[3 * i + j]);
				end else begin
					val = (dq.side.ovf[3 * i + j] || dq.lq[3 * i + j][ELEM_W-1])
						? elem_t'(MAXV) : elem_t'(dq.lq[3 * i + j]);
				end
				if (!(i < int'(dq.side.dim) && j < int'(dq.side.dim))) begin
					res_c[3 * i + j] = '0;
				end else if (dq.side.singular) begin
					res_c[3 * i + j] = dq.side.orig[3 * i + j];
				end else begin
					res_c[3 * i + j] = val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv9 && dq_valid) begin
			res_s9.r11         <= res_c[0];
			res_s9.r12         <= res_c[1];
			res_s9.r13         <= res_c[2];
			res_s9.r21         <= res_c[3];
			res_s9.r22         <= res_c[4];
			res_s9.r23         <= res_c[5];
			res_s9.r31         <= res_c[6];
			res_s9.r32         <= res_c[7];
			res_s9.r33         <= res_c[8];
			res_s9.determinant <= dq.side.singular ? elem_t'(0) : dq.side.det_out;
			res_s9.singular    <= dq.side.singular;
		end
	end

	assign out_valid = vld_s9;
	assign out_data  = res_s9;

endmodule
